[sv/cmau_pkg.sv]
package cmau_pkg;

  // Operation codes carried by each request
  typedef enum logic [1:0] {
    MODE_REDUCE     = 2'd0,
    MODE_REDUCE_ADD = 2'd1,
    MODE_ADD        = 2'd2,
    MODE_TO_RESIDUE = 2'd3
  } mode_t;

  localparam int unsigned OPER_W  = 64;
  localparam int unsigned MOD_W   = 31;
  localparam int unsigned RES_W   = 32;
  localparam int unsigned DIV_STAGES = OPER_W;

  // Payload of one request while it moves through the remainder pipeline
  typedef struct packed {
    mode_t               mode;
    logic                neg_a;
    logic                neg_b;
    logic [RES_W-1:0]    lo_a;
    logic [RES_W-1:0]    lo_b;
    logic [OPER_W-1:0]   dvd_a;
    logic [OPER_W-1:0]   dvd_b;
    logic [MOD_W-1:0]    rem_a;
    logic [MOD_W-1:0]    rem_b;
  } div_item_t;

endpackage

[sv/cmau_div_step.sv]
module cmau_div_step (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [cmau_pkg::MOD_W-1:0]        modulus,
  input  logic                              in_valid,
  input  cmau_pkg::div_item_t               in_item,
  output logic                              out_valid,
  output cmau_pkg::div_item_t               out_item
);

  logic                      valid_r;
  cmau_pkg::div_item_t       item_r;
  cmau_pkg::div_item_t       item_nxt;

  // One restoring step: bring in the next dividend bit, subtract m if it fits
  function automatic logic [cmau_pkg::MOD_W-1:0] rem_step(
    input logic [cmau_pkg::MOD_W-1:0] rem,
    input logic                       next_bit,
    input logic [cmau_pkg::MOD_W-1:0] m
  );
    logic [cmau_pkg::MOD_W:0] sh;
    sh = {rem, next_bit};
    if (sh >= {1'b0, m}) begin
      sh = sh - {1'b0, m};
    end
    return sh[cmau_pkg::MOD_W-1:0];
  endfunction

  // Advance both lanes by one quotient bit
  always_comb begin
    item_nxt       = in_item;
    item_nxt.rem_a = rem_step(in_item.rem_a, in_item.dvd_a[cmau_pkg::OPER_W-1], modulus);
    item_nxt.rem_b = rem_step(in_item.rem_b, in_item.dvd_b[cmau_pkg::OPER_W-1], modulus);
    item_nxt.dvd_a = {in_item.dvd_a[cmau_pkg::OPER_W-2:0], 1'b0};
    item_nxt.dvd_b = {in_item.dvd_b[cmau_pkg::OPER_W-2:0], 1'b0};
  end

  // Valid travels with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

[sv/centered_modular_arith_unit.sv]
// Centered modular arithmetic unit.
// A request is taken on a rising edge with start high and busy low; it carries
// in_mode, in_operand_a and in_operand_b. Modes: reduce a to its centered
// residue, reduce both and add, add two centered values, or turn a centered
// value into its residue in 0..m-1. A zero modulus gives a result of 0.
// The modulus is written on the cfg channel (cfg_valid and cfg_ready high)
// and should only change while no request is in flight.
// Each request passes through 69 register stages: one entry stage, one stage
// per bit of the 64-bit operands in the restoring remainder pipeline, then
// four stages for sign fix, centering, addition and the final wrap
// correction. Each result shows on out_result for one cycle with out_valid
// high.
// Throughput is one request per cycle, set by the fully pipelined remainder
// chain; requests and results stream without gaps.
// The receiver cannot hold results off, so busy never rises after reset.
// Reset is synchronous and active low: it empties the pipeline, sets the
// modulus to 1 and keeps busy high (cfg_ready low) during reset only.
module centered_modular_arith_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_mode,
  input  logic signed [63:0]          in_operand_a,
  input  logic signed [63:0]          in_operand_b,
  output logic                        out_valid,
  output logic signed [31:0]          out_result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [30:0]                 cfg_modulus
);

  localparam int unsigned MW = cmau_pkg::MOD_W;
  localparam int unsigned RW = cmau_pkg::RES_W;
  localparam int unsigned SW = RW + 2;
  localparam int unsigned NS = cmau_pkg::DIV_STAGES;

  logic                     busy_r;
  logic [MW-1:0]            modulus_r;
  logic                     accept;

  logic                     stg_valid [0:NS];
  cmau_pkg::div_item_t      stg_item  [0:NS];
  logic                     entry_valid_r;
  cmau_pkg::div_item_t      entry_r;
  cmau_pkg::div_item_t      entry_nxt;

  logic                     f1_valid_r;
  cmau_pkg::mode_t          f1_mode_r;
  logic [MW-1:0]            f1_fix_a_r, f1_fix_b_r;
  logic [RW-1:0]            f1_lo_a_r, f1_lo_b_r;
  logic [MW-1:0]            f1_fix_a_nxt, f1_fix_b_nxt;

  logic                     f2_valid_r;
  cmau_pkg::mode_t          f2_mode_r;
  logic signed [RW-1:0]     f2_cen_a_r, f2_cen_b_r;
  logic [RW-1:0]            f2_lo_a_r, f2_lo_b_r;
  logic signed [RW-1:0]     f2_cen_a_nxt, f2_cen_b_nxt;
  logic [MW-1:0]            half_up;

  logic                     f3_valid_r;
  logic signed [SW-1:0]     f3_sum_r;
  logic                     f3_corr_r;
  logic signed [SW-1:0]     f3_sum_nxt;
  logic                     f3_corr_nxt;

  logic                     out_valid_r;
  logic signed [RW-1:0]     out_result_r;
  logic signed [RW-1:0]     out_result_nxt;
  logic signed [SW-1:0]     mod_s, hi_s, lo_s, fin_s;

  // Control: busy only while in reset; modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      modulus_r <= MW'(1);
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        modulus_r <= cfg_modulus;
      end
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;
  assign accept    = start && !busy_r;

  // Entry stage: take magnitudes and keep signs and low words
  always_comb begin
    entry_nxt       = '0;
    entry_nxt.mode  = cmau_pkg::mode_t'(in_mode);
    entry_nxt.neg_a = in_operand_a[63];
    entry_nxt.neg_b = in_operand_b[63];
    entry_nxt.lo_a  = in_operand_a[RW-1:0];
    entry_nxt.lo_b  = in_operand_b[RW-1:0];
    entry_nxt.dvd_a = in_operand_a[63] ? (~in_operand_a + 64'sd1) : in_operand_a;
    entry_nxt.dvd_b = in_operand_b[63] ? (~in_operand_b + 64'sd1) : in_operand_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= 1'b0;
    end else begin
      entry_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign stg_valid[0] = entry_valid_r;
  assign stg_item[0]  = entry_r;

  // Remainder pipeline, one dividend bit per stage
  for (genvar i = 0; i < NS; i++) begin : g_div
    cmau_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .modulus   (modulus_r),
      .in_valid  (stg_valid[i]),
      .in_item   (stg_item[i]),
      .out_valid (stg_valid[i+1]),
      .out_item  (stg_item[i+1])
    );
  end

  // Stage F1: apply the dividend sign to the remainder (floor to 0..m-1)
  always_comb begin
    f1_fix_a_nxt = (stg_item[NS].neg_a && (stg_item[NS].rem_a != '0)) ?
                   (modulus_r - stg_item[NS].rem_a) : stg_item[NS].rem_a;
    f1_fix_b_nxt = (stg_item[NS].neg_b && (stg_item[NS].rem_b != '0)) ?
                   (modulus_r - stg_item[NS].rem_b) : stg_item[NS].rem_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= stg_valid[NS];
    end
  end

  always_ff @(posedge clk) begin
    f1_mode_r  <= stg_item[NS].mode;
    f1_fix_a_r <= f1_fix_a_nxt;
    f1_fix_b_r <= f1_fix_b_nxt;
    f1_lo_a_r  <= stg_item[NS].lo_a;
    f1_lo_b_r  <= stg_item[NS].lo_b;
  end

  // Stage F2: move residues at or above ceil(m/2) down by m
  always_comb begin
    half_up      = MW'((RW'(modulus_r) + RW'(1)) >> 1);
    f2_cen_a_nxt = (f1_fix_a_r >= half_up) ?
                   ($signed({1'b0, f1_fix_a_r}) - $signed({1'b0, modulus_r})) :
                   $signed({1'b0, f1_fix_a_r});
    f2_cen_b_nxt = (f1_fix_b_r >= half_up) ?
                   ($signed({1'b0, f1_fix_b_r}) - $signed({1'b0, modulus_r})) :
                   $signed({1'b0, f1_fix_b_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_valid_r <= 1'b0;
    end else begin
      f2_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    f2_mode_r  <= f1_mode_r;
    f2_cen_a_r <= f2_cen_a_nxt;
    f2_cen_b_r <= f2_cen_b_nxt;
    f2_lo_a_r  <= f1_lo_a_r;
    f2_lo_b_r  <= f1_lo_b_r;
  end

  // Stage F3: pick operands per mode and add
  always_comb begin
    mod_s       = $signed(SW'(modulus_r));
    f3_sum_nxt  = '0;
    f3_corr_nxt = 1'b0;
    case (f2_mode_r)
      cmau_pkg::MODE_REDUCE: begin
        f3_sum_nxt = SW'(f2_cen_a_r);
      end
      cmau_pkg::MODE_REDUCE_ADD: begin
        f3_sum_nxt  = SW'(f2_cen_a_r) + SW'(f2_cen_b_r);
        f3_corr_nxt = 1'b1;
      end
      cmau_pkg::MODE_ADD: begin
        f3_sum_nxt  = SW'($signed(f2_lo_a_r)) + SW'($signed(f2_lo_b_r));
        f3_corr_nxt = 1'b1;
      end
      cmau_pkg::MODE_TO_RESIDUE: begin
        f3_sum_nxt = SW'($signed(f2_lo_a_r)) + (f2_lo_a_r[RW-1] ? mod_s : '0);
      end
      default: begin
        f3_sum_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f3_valid_r <= 1'b0;
    end else begin
      f3_valid_r <= f2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    f3_sum_r  <= f3_sum_nxt;
    f3_corr_r <= f3_corr_nxt;
  end

  // Stage F4: one wrap correction against the centered bounds
  always_comb begin
    hi_s  = $signed(SW'((RW'(modulus_r) - RW'(1)) >> 1));
    lo_s  = -$signed(SW'(modulus_r >> 1));
    fin_s = f3_sum_r;
    if (f3_corr_r) begin
      if (f3_sum_r > hi_s) begin
        fin_s = f3_sum_r - mod_s;
      end else if (f3_sum_r < lo_s) begin
        fin_s = f3_sum_r + mod_s;
      end
    end
    out_result_nxt = (modulus_r == '0) ? '0 : $signed(fin_s[RW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= f3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

[sim/tb_centered_modular_arith_unit.sv]
module tb_centered_modular_arith_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 80;

  typedef struct {
    cmau_pkg::mode_t mode;
    logic [63:0]     a;
    logic [63:0]     b;
  } arith_req_t;

  typedef struct {
    arith_req_t         req;
    logic signed [31:0] result;
  } residue_expect_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  cmau_pkg::mode_t    in_mode = cmau_pkg::MODE_REDUCE;
  logic signed [63:0] in_operand_a = '0;
  logic signed [63:0] in_operand_b = '0;
  logic               out_valid;
  logic signed [31:0] out_result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [30:0]        cfg_modulus = 31'd1;

  arith_req_t      pending_reqs[$];
  residue_expect_t expected_residues[$];
  arith_req_t      next_req;
  residue_expect_t new_exp;
  residue_expect_t got_exp;

  logic [30:0] modulus_shadow = 31'd1;
  logic        req_taken = 1'b0;
  int          send_idle_pct = 0;
  int          queued_cnt = 0;
  int          accepted_cnt = 0;
  int          checked_cnt = 0;
  int          cfg_writes = 0;
  int          fail_cnt = 0;
  int          phases_run = 0;
  int          stall_cycles = 0;

  centered_modular_arith_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_mode     (in_mode),
    .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b),
    .out_valid   (out_valid),
    .out_result  (out_result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_modulus (cfg_modulus)
  );

  always #10 clk = ~clk;

  // Centered residue of x in -(m/2) .. ceil(m/2)-1
  function automatic longint center_mod(input longint x, input longint m);
    longint r;
    r = x % m;
    if (r < 0) r += m;
    if (r >= m / 2 + m % 2) r -= m;
    return r;
  endfunction

  // Add with a single wrap step toward the centered range
  function automatic longint wrap_add(input longint a, input longint b, input longint m);
    longint s;
    s = a + b;
    if (s > (m - 1) / 2) s -= m;
    else if (s < -(m / 2)) s += m;
    return s;
  endfunction

  function automatic logic [31:0] predict_residue(input logic [30:0] mod_val,
                                                  input arith_req_t req);
    longint m;
    longint ca;
    longint cb;
    longint r;
    m  = longint'({33'd0, mod_val});
    ca = longint'($signed(req.a[31:0]));
    cb = longint'($signed(req.b[31:0]));
    r  = 0;
    if (m != 0) begin
      case (req.mode)
        cmau_pkg::MODE_REDUCE:     r = center_mod(req.a, m);
        cmau_pkg::MODE_REDUCE_ADD: r = wrap_add(center_mod(req.a, m), center_mod(req.b, m), m);
        cmau_pkg::MODE_ADD:        r = wrap_add(ca, cb, m);
        default:                   r = (ca < 0) ? ca + m : ca;
      endcase
    end
    return r[31:0];
  endfunction

  // Pick one operand: full range, near a wrap boundary, small, or centered
  function automatic logic [63:0] pick_operand(input longint m, input int style);
    longint q;
    longint off;
    longint c;
    logic [63:0] v;
    v = {$urandom, $urandom};
    case (style)
      1: begin
        q = longint'($signed($urandom));
        case ($urandom_range(5))
          0: off = m / 2 + m % 2 - 1;
          1: off = m / 2 + m % 2;
          2: off = -(m / 2);
          3: off = -(m / 2) - 1;
          4: off = 0;
          default: off = m - 1;
        endcase
        v = q * m + off;
      end
      2: begin
        v = longint'($urandom_range(2000)) - 1000;
      end
      3: begin
        c = (m == 0) ? longint'($signed($urandom)) : center_mod(v, m);
        if ($urandom_range(1)) v = c;
        else v = {$urandom, c[31:0]};
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_req(input cmau_pkg::mode_t mode, input logic [63:0] a,
                           input logic [63:0] b);
    arith_req_t req;
    req.mode = mode;
    req.a    = a;
    req.b    = b;
    pending_reqs.insert(pending_reqs.size(), req);
    queued_cnt++;
  endtask

  // Mostly centered operands for the add and convert modes, anything otherwise
  task automatic queue_random();
    cmau_pkg::mode_t mode;
    longint          m;
    int              sa;
    int              sb;
    mode = cmau_pkg::mode_t'($urandom_range(3));
    m    = longint'({33'd0, modulus_shadow});
    sa   = $urandom_range(3);
    sb   = $urandom_range(3);
    if (mode == cmau_pkg::MODE_ADD || mode == cmau_pkg::MODE_TO_RESIDUE) begin
      if ($urandom_range(9) < 7) sa = 3;
      if ($urandom_range(9) < 7) sb = 3;
    end
    queue_req(mode, pick_operand(m, sa), pick_operand(m, sb));
  endtask

  // Hold until every request is taken and every result has come back
  task automatic drain();
    while (accepted_cnt != queued_cnt || expected_residues.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_modulus(input logic [30:0] value);
    int target;
    target = cfg_writes + 1;
    @(negedge clk);
    cfg_modulus <= value;
    cfg_valid   <= 1'b1;
    do @(negedge clk); while (cfg_writes != target);
    cfg_valid <= 1'b0;
  endtask

  // Random requests, with a full drain halfway through
  task automatic run_phase(input int idle_pct, input int n_items);
    int i;
    send_idle_pct = idle_pct;
    for (i = 0; i < n_items; i++) begin
      if (i == n_items / 2) drain();
      queue_random();
    end
    drain();
    phases_run++;
  endtask

  // Stimulus sequence
  initial begin
    longint m;
    longint hi_c;
    longint lo_c;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Reset modulus first, no write
    run_phase(25, 40);

    // Directed requests at the largest modulus
    write_modulus(31'h7fff_ffff);
    send_idle_pct = 25;
    m    = longint'({33'd0, modulus_shadow});
    hi_c = m / 2 + m % 2 - 1;
    lo_c = -(m / 2);
    queue_req(cmau_pkg::MODE_REDUCE, 64'h8000_0000_0000_0000, 64'h0);
    queue_req(cmau_pkg::MODE_REDUCE, 64'h7fff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    queue_req(cmau_pkg::MODE_REDUCE, 64'h0, 64'h7fff_ffff_ffff_ffff);
    queue_req(cmau_pkg::MODE_REDUCE, -64'sd1, 64'h0);
    queue_req(cmau_pkg::MODE_REDUCE, hi_c, 64'h0);
    queue_req(cmau_pkg::MODE_REDUCE, hi_c + 1, 64'h0);
    queue_req(cmau_pkg::MODE_REDUCE, lo_c, 64'h0);
    queue_req(cmau_pkg::MODE_REDUCE, lo_c - 1, 64'h0);
    queue_req(cmau_pkg::MODE_REDUCE, m, -m);
    queue_req(cmau_pkg::MODE_REDUCE_ADD, 64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff);
    queue_req(cmau_pkg::MODE_REDUCE_ADD, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    queue_req(cmau_pkg::MODE_REDUCE_ADD, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
    queue_req(cmau_pkg::MODE_REDUCE_ADD, hi_c, hi_c);
    queue_req(cmau_pkg::MODE_REDUCE_ADD, lo_c, lo_c);
    queue_req(cmau_pkg::MODE_ADD, hi_c, hi_c);
    queue_req(cmau_pkg::MODE_ADD, lo_c, lo_c);
    queue_req(cmau_pkg::MODE_ADD, hi_c, lo_c);
    // Operands outside the centered range, junk in the upper words
    queue_req(cmau_pkg::MODE_ADD, 64'hdead_beef_7fff_ffff, 64'h1234_5678_7fff_ffff);
    queue_req(cmau_pkg::MODE_ADD, 64'h0000_0000_8000_0000, 64'hffff_ffff_8000_0000);
    queue_req(cmau_pkg::MODE_TO_RESIDUE, -64'sd1, 64'h5a5a_a5a5_5a5a_a5a5);
    queue_req(cmau_pkg::MODE_TO_RESIDUE, lo_c, 64'h0);
    queue_req(cmau_pkg::MODE_TO_RESIDUE, hi_c, 64'h0);
    queue_req(cmau_pkg::MODE_TO_RESIDUE, 64'h0, -64'sd1);
    queue_req(cmau_pkg::MODE_TO_RESIDUE, 64'h7fff_ffff_8000_0000, 64'h0);
    run_phase(25, 100);

    // Zero modulus forces every result to zero
    write_modulus(31'd0);
    run_phase(25, 60);

    write_modulus(31'd2);
    run_phase(54, 80);
    write_modulus(31'($urandom_range(32'h4000_0000, 32'h7fff_fffe)) & ~31'd1);
    run_phase(54, 120);
    write_modulus(31'd3);
    run_phase(54, 80);

    write_modulus(31'($urandom_range(1, 1000)));
    run_phase(0, 120);
    write_modulus(31'($urandom_range(32'h4000_0000, 32'h7fff_fffe)) | 31'd1);
    run_phase(0, 200);
    write_modulus(31'd1);
    run_phase(0, 60);

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Checked %0d results across %0d phases and %0d modulus writes,", checked_cnt,
             phases_run, cfg_writes);
    $display("all four modes incl. zero, even, odd and extreme moduli; %0d mismatches.",
             fail_cnt);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Driver: advance to the next request once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_reqs.pop_front();
        in_mode      <= next_req.mode;
        in_operand_a <= next_req.a;
        in_operand_b <= next_req.b;
        start        <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predict on each taken request, check each strobed result
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        new_exp.req.mode = in_mode;
        new_exp.req.a    = in_operand_a;
        new_exp.req.b    = in_operand_b;
        new_exp.result   = predict_residue(modulus_shadow, new_exp.req);
        expected_residues.insert(expected_residues.size(), new_exp);
        accepted_cnt <= accepted_cnt + 1;
        req_taken    <= 1'b1;
      end else begin
        req_taken <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        modulus_shadow <= cfg_modulus;
        cfg_writes     <= cfg_writes + 1;
      end
      if (out_valid) begin
        if (expected_residues.size() == 0) begin
          $display("%0t: result %0d with no request outstanding", $time, out_result);
          fail_cnt <= fail_cnt + 1;
        end else begin
          got_exp = expected_residues.pop_front();
          checked_cnt <= checked_cnt + 1;
          if (out_result !== got_exp.result) begin
            $display("%0t: mode %0d a=%h b=%h m=%0d: expected %0d, actual %0d", $time,
                     got_exp.req.mode, got_exp.req.a, got_exp.req.b, modulus_shadow,
                     got_exp.result, out_result);
            fail_cnt <= fail_cnt + 1;
          end
        end
      end
    end else begin
      req_taken <= 1'b0;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no activity for %0d cycles", $time, stall_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
